[rtl/rkc_pkg.sv]
// ----------------------------------------------------------------------------
// Running-key cipher package
// Shared types and character constants for the running-key cipher block.
// ----------------------------------------------------------------------------
package rkc_pkg;

  // Letters are held in the key store as 0..25.
  localparam int unsigned LetterW = 5;
  localparam int unsigned AlphaLen = 26;

  localparam logic [7:0] CharLowA = 8'h61;  // 'a'
  localparam logic [7:0] CharLowZ = 8'h7a;  // 'z'
  localparam logic [7:0] CharUpA  = 8'h41;  // 'A'
  localparam logic [7:0] CharUpZ  = 8'h5a;  // 'Z'
  localparam logic [7:0] CharSpace = 8'h20; // ' '

  // Configuration port.
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam logic RegPageSelect = 1'b0;

  typedef enum logic [1:0] {
    OP_ENCRYPT = 2'd0,
    OP_DECRYPT = 2'd1,
    OP_KEY     = 2'd2
  } rkc_op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_BAD_KEY   = 3'd2,
    ST_BAD_PAGE  = 3'd3,
    ST_BAD_TEXT  = 3'd4,
    ST_FULL      = 3'd5
  } rkc_status_e;

  // Decisions taken on the accepted byte, handed to the result stage.
  typedef struct packed {
    logic [7:0]  in_char;
    rkc_status_e status;
    logic        cipher;    // apply the key letter
    logic        decrypt;
    logic        upper;
    logic        key_zero;  // page 0 always reads as 'a'
  } rkc_s1_t;

endpackage

[rtl/rkc_in_if.sv]
// ----------------------------------------------------------------------------
// Running-key cipher input channel
// Valid/ready channel carrying one text or key byte per transfer.
// ----------------------------------------------------------------------------
interface rkc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] in_char;
  logic       first;

  modport source (output valid, output opcode, output in_char, output first, input ready);
  modport sink   (input valid, input opcode, input in_char, input first, output ready);
endinterface

[rtl/rkc_out_if.sv]
// ----------------------------------------------------------------------------
// Running-key cipher output channel
// Valid/ready channel carrying one result byte and its status per transfer.
// ----------------------------------------------------------------------------
interface rkc_out_if;
  logic                valid;
  logic                ready;
  logic [7:0]          out_char;
  rkc_pkg::rkc_status_e status;

  modport source (output valid, output out_char, output status, input ready);
  modport sink   (input valid, input out_char, input status, output ready);
endinterface

[rtl/rkc_apb_regs.sv]
// ----------------------------------------------------------------------------
// Running-key cipher configuration registers
// APB-style register file holding the page select register.
// ----------------------------------------------------------------------------
module rkc_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rkc_pkg::PaddrW-1:0] paddr,
  input  logic [rkc_pkg::PdataW-1:0] pwdata,
  output logic [rkc_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  output logic [1:0]                 page_select_o
);
  import rkc_pkg::*;

  logic [1:0] page_select_q;
  logic       reg_idx;

  // Registers sit on 4-byte boundaries; the low address bits are ignored.
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_select_q <= '0;
    end else if (psel && penable && pwrite && pready && (reg_idx == RegPageSelect)) begin
      page_select_q <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == RegPageSelect) begin
      prdata = {{(PdataW-2){1'b0}}, page_select_q};
    end
  end

  assign page_select_o = page_select_q;

endmodule

[rtl/rkc_key_ram.sv]
// ----------------------------------------------------------------------------
// Running-key cipher key store
// Single write port, single registered read port memory of key letters.
// ----------------------------------------------------------------------------
module rkc_key_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [rkc_pkg::LetterW-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [rkc_pkg::LetterW-1:0] rdata_o
);
  import rkc_pkg::*;

  logic [LetterW-1:0] mem [Depth];
  logic [LetterW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rkc_ctrl.sv]
// ----------------------------------------------------------------------------
// Running-key cipher control
// Key loading, page bookkeeping, key pointer and the first pipeline stage.
// ----------------------------------------------------------------------------
module rkc_ctrl #(
  parameter int unsigned Pages  = 4,
  parameter int unsigned KeyLen = 256,
  parameter int unsigned AddrW  = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  opcode_i,
  input  logic [7:0]                  in_char_i,
  input  logic                        first_i,
  input  logic [1:0]                  page_select_i,
  input  logic                        out_take_i,
  output logic                        s1_valid_o,
  output rkc_pkg::rkc_s1_t            s1_o,
  output logic                        ram_we_o,
  output logic [AddrW-1:0]            ram_waddr_o,
  output logic [rkc_pkg::LetterW-1:0] ram_wdata_o,
  output logic                        ram_re_o,
  output logic [AddrW-1:0]            ram_raddr_o
);
  import rkc_pkg::*;

  localparam int unsigned LenW = $clog2(KeyLen + 1);
  localparam int unsigned PcW  = $clog2(Pages + 1);
  localparam int unsigned PgW  = (Pages > 1) ? $clog2(Pages) : 1;

  logic [LenW-1:0] len_q [Pages];
  logic [LenW-1:0] load_len_q, load_len_d;
  logic [PcW-1:0]  page_count_q, page_count_d;
  logic [PgW-1:0]  pbl_q, pbl_d;
  logic            load_inv_q, load_inv_d;
  logic [LenW-1:0] ptr_q, ptr_d;
  logic            s1_valid_q;
  rkc_s1_t         s1_q, s1_d;

  logic            accept;
  logic            len_we;
  logic [PgW-1:0]  len_idx;
  logic [LenW-1:0] len_val;
  logic [LenW-1:0] sel_len;
  logic [LenW-1:0] ptr_eff;
  logic [LenW-1:0] len_eff;
  logic [PgW-1:0]  pbl_eff;
  logic            inv_eff;
  logic            full_open;
  logic            page_ok;
  logic            is_lower;
  logic            is_upper;
  logic            is_space;

  assign in_ready_o = !s1_valid_q || out_take_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_lower = (in_char_i >= CharLowA) && (in_char_i <= CharLowZ);
  assign is_upper = (in_char_i >= CharUpA) && (in_char_i <= CharUpZ);
  assign is_space = (in_char_i == CharSpace);

  assign full_open = (page_count_q >= PcW'(Pages));
  assign page_ok   = (32'(page_select_i) < 32'(page_count_q)) && (32'(page_select_i) < Pages);

  // Length of the page that supplies the running key.
  always_comb begin
    sel_len = '0;
    for (int i = 0; i < Pages; i++) begin
      if (32'(page_select_i) == i) begin
        sel_len = len_q[i];
      end
    end
  end

  always_comb begin
    load_len_d   = load_len_q;
    page_count_d = page_count_q;
    pbl_d        = pbl_q;
    load_inv_d   = load_inv_q;
    ptr_d        = ptr_q;
    len_we       = 1'b0;
    len_idx      = pbl_q;
    len_val      = load_len_q;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;
    ptr_eff      = first_i ? '0 : ptr_q;
    pbl_eff      = pbl_q;
    len_eff      = load_len_q;
    inv_eff      = load_inv_q;
    s1_d         = '{in_char: in_char_i, status: ST_BAD_TEXT, cipher: 1'b0,
                     decrypt: (opcode_i == OP_DECRYPT), upper: is_upper,
                     key_zero: (page_select_i == 2'd0)};

    if (accept) begin
      unique case (opcode_i)
        OP_KEY: begin
          // A first key byte opens the next page, unless the store is full.
          if (first_i) begin
            if (full_open) begin
              inv_eff = 1'b1;
            end else begin
              pbl_eff      = PgW'(page_count_q);
              len_eff      = '0;
              inv_eff      = 1'b0;
              page_count_d = page_count_q + PcW'(1);
              len_we       = 1'b1;
            end
          end
          len_idx = pbl_eff;
          len_val = len_eff;
          priority if (inv_eff) begin
            s1_d.status = ST_FULL;
          end else if (is_space) begin
            s1_d.status = ST_OK;
          end else if (!is_lower) begin
            s1_d.status = ST_BAD_KEY;
          end else if (len_eff >= LenW'(KeyLen)) begin
            s1_d.status = ST_FULL;
          end else begin
            s1_d.status = ST_OK;
            ram_we_o    = 1'b1;
            len_we      = 1'b1;
            len_val     = len_eff + LenW'(1);
          end
          pbl_d      = pbl_eff;
          load_inv_d = inv_eff;
          load_len_d = len_val;
        end
        OP_ENCRYPT, OP_DECRYPT: begin
          ptr_d = ptr_eff;
          priority if (is_space) begin
            s1_d.status = ST_OK;
          end else if (!is_lower && !is_upper) begin
            s1_d.status = ST_BAD_TEXT;
          end else if (!page_ok) begin
            s1_d.status = ST_BAD_PAGE;
          end else if (ptr_eff >= sel_len) begin
            s1_d.status = ST_EXHAUSTED;
          end else begin
            s1_d.status = ST_OK;
            s1_d.cipher = 1'b1;
            ram_re_o    = 1'b1;
            ptr_d       = ptr_eff + LenW'(1);
          end
        end
        default: begin
          s1_d.status = ST_BAD_TEXT;
        end
      endcase
    end
  end

  assign ram_waddr_o = AddrW'(pbl_eff) * AddrW'(KeyLen) + AddrW'(len_eff);
  assign ram_wdata_o = LetterW'(in_char_i - CharLowA);
  assign ram_raddr_o = AddrW'(page_select_i) * AddrW'(KeyLen) + AddrW'(ptr_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Pages; i++) begin
        len_q[i] <= (i == 0) ? LenW'(KeyLen) : '0;
      end
      load_len_q   <= LenW'(KeyLen);
      page_count_q <= PcW'(1);
      pbl_q        <= '0;
      load_inv_q   <= 1'b0;
      ptr_q        <= '0;
      s1_valid_q   <= 1'b0;
    end else begin
      if (len_we) begin
        len_q[len_idx] <= len_val;
      end
      load_len_q   <= load_len_d;
      page_count_q <= page_count_d;
      pbl_q        <= pbl_d;
      load_inv_q   <= load_inv_d;
      ptr_q        <= ptr_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (out_take_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

[rtl/rkc_out_stage.sv]
// ----------------------------------------------------------------------------
// Running-key cipher result stage
// Mod-26 letter arithmetic and the output register.
// ----------------------------------------------------------------------------
module rkc_out_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s1_valid_i,
  input  rkc_pkg::rkc_s1_t            s1_i,
  input  logic [rkc_pkg::LetterW-1:0] key_i,
  output logic                        take_o,
  rkc_out_if.source                   out_o
);
  import rkc_pkg::*;

  logic               valid_q;
  logic [7:0]         char_q, char_d;
  rkc_status_e        status_q;
  logic [7:0]         base;
  logic [LetterW-1:0] letter;
  logic [LetterW-1:0] key;
  logic [LetterW:0]   sum;
  logic [LetterW:0]   wrapped;
  logic               load;

  assign take_o = !valid_q || out_o.ready;
  assign load   = s1_valid_i && take_o;

  assign base   = s1_i.upper ? CharUpA : CharLowA;
  assign letter = LetterW'(s1_i.in_char - base);
  assign key    = s1_i.key_zero ? '0 : key_i;

  // Both sums stay below 52, so one conditional subtract brings them into range.
  always_comb begin
    if (s1_i.decrypt) begin
      sum = {1'b0, letter} + (LetterW+1)'(AlphaLen) - {1'b0, key};
    end else begin
      sum = {1'b0, letter} + {1'b0, key};
    end
    wrapped = (sum >= (LetterW+1)'(AlphaLen)) ? sum - (LetterW+1)'(AlphaLen) : sum;
    char_d  = s1_i.cipher ? base + 8'(wrapped) : s1_i.in_char;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q   <= char_d;
      status_q <= s1_i.status;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.out_char = char_q;
  assign out_o.status   = status_q;

endmodule

[rtl/running_key_cipher_top.sv]
// A result passes through the input stage register and then the result register.
// Throughput: one byte per cycle unless the output stalls; the single read port reads at most once per byte.
// Reset: asynchronous, active low; page 0 reads as all 'a' at once, with no clearing pass.
// ----------------------------------------------------------------------------
// Running-key cipher top level
// Running-key Vigenere cipher over a byte stream with an on-chip key store.
// ----------------------------------------------------------------------------
module running_key_cipher_top #(
  parameter int unsigned Pages  = 4,
  parameter int unsigned KeyLen = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rkc_in_if.sink                     in_i,
  rkc_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rkc_pkg::PaddrW-1:0] paddr,
  input  logic [rkc_pkg::PdataW-1:0] pwdata,
  output logic [rkc_pkg::PdataW-1:0] prdata,
  output logic                       pready
);
  import rkc_pkg::*;

  // The key store spans every page, one letter per entry. Page 0 is never
  // written, since opening a page always takes the next free page and page 0
  // starts full; its reads are forced to the letter 'a' in the result stage.
  // Other pages are only read below their stored length, so they need no
  // initialisation.
  localparam int unsigned Depth = Pages * KeyLen;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic               s1_valid;
  rkc_s1_t            s1;
  logic               out_take;
  logic [1:0]         page_select;
  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [LetterW-1:0] ram_wdata;
  logic               ram_re;
  logic [AddrW-1:0]   ram_raddr;
  logic [LetterW-1:0] ram_rdata;

  // The user must write configuration only while the pipeline is empty; the block itself does not enforce this.
  rkc_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .page_select_o (page_select)
  );

  // First stage: all bookkeeping is updated on the input transfer itself and
  // the key letter read is issued in the same cycle, so the next byte sees the
  // updated pointer and lengths straight away.
  rkc_ctrl #(
    .Pages  (Pages),
    .KeyLen (KeyLen),
    .AddrW  (AddrW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .opcode_i      (in_i.opcode),
    .in_char_i     (in_i.in_char),
    .first_i       (in_i.first),
    .page_select_i (page_select),
    .out_take_i    (out_take),
    .s1_valid_o    (s1_valid),
    .s1_o          (s1),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr)
  );

  // The read data register only loads on a text transfer, so it holds its
  // letter for as long as the first stage is stalled.
  rkc_key_ram #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Second stage: mod-26 add or subtract into the output register, whose
  // ready feeds back combinationally to the input ready.
  rkc_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_i       (s1),
    .key_i      (ram_rdata),
    .take_o     (out_take),
    .out_o      (out_o)
  );

endmodule
